FILE: sv/cdtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdtp_pkg
// shared types and constants of the countdown timer pool
// ----------------------------------------------------------------------------
package cdtp_pkg;

    // opcodes
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_CHECK = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // slot states
    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_ELAPSED = 2'd3;

    // check results
    localparam logic [1:0] CHK_RUNNING     = 2'd0;
    localparam logic [1:0] CHK_EXPIRED     = 2'd1;
    localparam logic [1:0] CHK_BAD_STATE   = 2'd2;
    localparam logic [1:0] CHK_BAD_HANDLE  = 2'd3;

    localparam logic [7:0]  HANDLE_PREFIX = 8'hCE;
    localparam logic [31:0] MAX_DELAY     = 32'h7FFF_FFFF;
    localparam logic [31:0] NO_COUNT      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ticks;
    } slot_entry_t;

endpackage

FILE: sv/countdown_timer_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_pool
// pool of countdown timers behind 16-bit handles, slot state held in a
// single-port-write, registered-read memory
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// -------   ---------  --------------------  ---------------------------
// in        input      in_valid / in_stall   opcode, handle, delay
// out       output     out_valid / out_stall ok, handle_out, status
//
// from accept, an item passes S_ISSUE, then S_LOOK (check, alloc with a valid handle)
// and/or S_SCAN (tick, alloc looking for a free slot), then S_DONE, which loads the
// output register. the memory gives one read per cycle, so alloc and tick sweep the
// slots one at a time; a new transfer is taken once the sequencer is back in S_IDLE.
// reset clears the per-entry valid bits, an entry never written reads as
// unused with no count; the memory itself is not cleared, so no clearing pass.
// a stalled result holds in the output register; the next item is taken and
// worked on, and only waits at its end until the output register frees.
//
module countdown_timer_pool #(
    parameter int SLOTS = 5
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [15:0] handle,
    input  logic [31:0] delay,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [15:0] handle_out,
    output logic [1:0]  status
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index width
    localparam int CW = $clog2(SLOTS + 1);                  // used count width

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_LOOK  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // captured command
    logic [2:0]    op_reg;
    logic [15:0]   handle_reg;
    logic [31:0]   delay_reg;
    logic          hvalid_reg;
    logic [IW-1:0] hidx_reg;
    logic          hvalid;

    logic [CW-1:0] in_use_reg, in_use_next;
    logic [IW-1:0] scan_reg, scan_next;

    // result being built
    logic          res_ok_reg, res_ok_next;
    logic [15:0]   res_hout_reg, res_hout_next;
    logic [1:0]    res_status_reg, res_status_next;

    // output register
    logic          out_valid_reg;
    logic          out_ok_reg;
    logic [15:0]   out_hout_reg;
    logic [1:0]    out_status_reg;
    logic          out_load;

    // slot memory and its valid bits
    cdtp_pkg::slot_entry_t mem [SLOTS];
    logic [SLOTS-1:0]      vld_reg;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    cdtp_pkg::slot_entry_t rd_data_reg;
    logic                  rd_vld_reg;
    cdtp_pkg::slot_entry_t rd_entry;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    cdtp_pkg::slot_entry_t mem_wdata;

    logic          in_accept;
    logic          scan_last;
    logic          pool_full;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // handle is valid when prefix matches and the index is inside the pool
    assign hvalid = (handle[15:8] == cdtp_pkg::HANDLE_PREFIX) && !handle[7]
                    && (32'(handle[7:0]) < SLOTS);

    // never-written entries read as the reset value
    assign rd_entry  = rd_vld_reg ? rd_data_reg
                                  : cdtp_pkg::slot_entry_t'{status: cdtp_pkg::ST_UNUSED,
                                                            ticks: cdtp_pkg::NO_COUNT};
    assign scan_last = (scan_reg == IW'(SLOTS - 1));
    assign pool_full = (in_use_reg >= CW'(SLOTS));

    // ------------------------------------------------------------------------
    // memory: one write, one registered read per cycle
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------------
    // command capture
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= opcode;
            handle_reg <= handle;
            delay_reg  <= delay;
            hvalid_reg <= hvalid;
            hidx_reg   <= handle[IW-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        scan_next       = scan_reg;
        res_ok_next     = res_ok_reg;
        res_hout_next   = res_hout_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = hidx_reg;
        mem_we          = 1'b0;
        mem_waddr       = hidx_reg;
        mem_wdata       = rd_entry;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                // defaults: input handle back, no success, status zero
                res_ok_next     = 1'b0;
                res_hout_next   = handle_reg;
                res_status_next = cdtp_pkg::CHK_RUNNING;
                state_next      = S_DONE;
                case (op_reg)
                    cdtp_pkg::OP_ALLOC:
                    begin
                        if (hvalid_reg && (in_use_reg != '0))
                        begin
                            rd_en      = 1'b1;
                            state_next = S_LOOK;
                        end
                        else if (!pool_full)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    cdtp_pkg::OP_FREE:
                    begin
                        // frees even an unused slot, count still drops
                        if (hvalid_reg && (in_use_reg != '0))
                        begin
                            mem_we        = 1'b1;
                            mem_wdata     = '{status: cdtp_pkg::ST_UNUSED,
                                              ticks: cdtp_pkg::NO_COUNT};
                            in_use_next   = in_use_reg - CW'(1);
                            res_ok_next   = 1'b1;
                            res_hout_next = '0;
                        end
                    end
                    cdtp_pkg::OP_START:
                    begin
                        if (hvalid_reg)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = '{status: cdtp_pkg::ST_RUNNING,
                                            ticks: delay_reg[31] ? cdtp_pkg::MAX_DELAY
                                                                 : delay_reg};
                            res_ok_next = 1'b1;
                        end
                    end
                    cdtp_pkg::OP_CHECK:
                    begin
                        if (hvalid_reg)
                        begin
                            rd_en      = 1'b1;
                            state_next = S_LOOK;
                        end
                        else
                        begin
                            res_status_next = cdtp_pkg::CHK_BAD_HANDLE;
                        end
                    end
                    cdtp_pkg::OP_TICK:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_LOOK:
            begin
                // entry of the caller's slot is on the read port
                state_next = S_DONE;
                if (op_reg == cdtp_pkg::OP_CHECK)
                begin
                    if (rd_entry.status == cdtp_pkg::ST_ELAPSED)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata.status = cdtp_pkg::ST_IDLE;
                        res_status_next  = cdtp_pkg::CHK_EXPIRED;
                    end
                    else if (rd_entry.status == cdtp_pkg::ST_RUNNING)
                    begin
                        res_status_next = cdtp_pkg::CHK_RUNNING;
                    end
                    else
                    begin
                        res_status_next = cdtp_pkg::CHK_BAD_STATE;
                    end
                end
                else
                begin
                    // alloc: confirm an idle slot, else look for a free one
                    if (rd_entry.status == cdtp_pkg::ST_IDLE)
                    begin
                        res_ok_next = 1'b1;
                    end
                    else if (!pool_full)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // entry scan_reg is on the read port, fetch the next one
                mem_waddr = scan_reg;
                if (!scan_last)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + IW'(1);
                    scan_next = scan_reg + IW'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
                if (op_reg == cdtp_pkg::OP_TICK)
                begin
                    if (rd_entry.status == cdtp_pkg::ST_RUNNING)
                    begin
                        if (rd_entry.ticks == '0)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{status: cdtp_pkg::ST_ELAPSED,
                                          ticks: cdtp_pkg::NO_COUNT};
                        end
                        else if (!rd_entry.ticks[31])
                        begin
                            mem_we          = 1'b1;
                            mem_wdata.ticks = rd_entry.ticks - 32'd1;
                        end
                    end
                end
                else if (rd_entry.status == cdtp_pkg::ST_UNUSED)
                begin
                    // alloc claims the first unused slot and stops
                    mem_we           = 1'b1;
                    mem_wdata.status = cdtp_pkg::ST_IDLE;
                    in_use_next      = in_use_reg + CW'(1);
                    res_ok_next      = 1'b1;
                    res_hout_next    = {cdtp_pkg::HANDLE_PREFIX, 8'(scan_reg)};
                    rd_en            = 1'b0;
                    state_next       = S_DONE;
                end
            end

            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_use_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        res_ok_reg     <= res_ok_next;
        res_hout_reg   <= res_hout_next;
        res_status_reg <= res_status_next;
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ok_reg     <= res_ok_reg;
            out_hout_reg   <= res_hout_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = out_ok_reg;
    assign handle_out = out_hout_reg;
    assign status     = out_status_reg;

`ifndef NO_ASSERTIONS
    // used count stays within the pool
    a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= CW'(SLOTS))
        else $error("slots in use above pool size");

    // a sweep never writes the entry it is reading in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && rd_en && (mem_waddr == rd_addr)))
        else $error("memory read and write to the same slot");

    // an accepted transfer starts the sequencer
    a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_ISSUE))
        else $error("accepted item not issued");

    // the output register is only reloaded once its result has been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");
`endif

endmodule
